### hdl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W     = WAY_W;
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 62;
    localparam int CNT_W      = 32;
    localparam int MODE_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SETB_W     = 3;
    localparam int BLKB_W     = 6;
    localparam int WAYS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FETCH  = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_STORE  = 2'd2,
        MODE_MODIFY = 2'd3
    } mode_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED = 2'd0,
        OUT_HIT     = 2'd1,
        OUT_MISS    = 2'd2,
        OUT_EVICT   = 2'd3
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]              valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    } row_t;

endpackage

`default_nettype wire

### hdl/sacl_ctrl.sv
`default_nettype none

module sacl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output sacl_pkg::ctrl_cmd_t     cmd
);

    sacl_pkg::state_t state_reg;
    sacl_pkg::state_t state_next;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.update;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sacl_pkg::ST_LOOK;
                end
            end
            sacl_pkg::ST_LOOK:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        cmd.accept = 1'b0;
        cmd.update = 1'b0;
        unique case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                cmd.accept = start;
            end
            sacl_pkg::ST_LOOK:
            begin
                busy       = 1'b1;
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

### hdl/sacl_dpath.sv
`default_nettype none

module sacl_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sacl_pkg::ctrl_cmd_t                cmd,
    input  wire logic [sacl_pkg::MODE_W-1:0]        mode,
    input  wire logic [sacl_pkg::ADDR_W-1:0]        access_address,
    input  wire logic                               cfg_valid,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [sacl_pkg::OUTCOME_W-1:0]          outcome,
    output logic                                    modify_second_hit,
    output logic [sacl_pkg::CNT_W-1:0]              hit_total,
    output logic [sacl_pkg::CNT_W-1:0]              miss_total,
    output logic [sacl_pkg::CNT_W-1:0]              eviction_total
);

    localparam int NW = sacl_pkg::MAX_WAYS;
    localparam int RW = sacl_pkg::RANK_W;
    localparam int WW = sacl_pkg::WAY_W;

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(
        input logic [sacl_pkg::CNT_W-1:0] v,
        input logic                       en
    );
        logic [sacl_pkg::CNT_W-1:0] r;
        r = v;
        if (en && (v != {sacl_pkg::CNT_W{1'b1}}))
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    // configuration
    logic [sacl_pkg::SETB_W-1:0] set_bits_reg;
    logic [sacl_pkg::BLKB_W-1:0] block_bits_reg;
    logic [sacl_pkg::WAYS_W-1:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= sacl_pkg::SETB_W'(1);
            block_bits_reg <= sacl_pkg::BLKB_W'(1);
            ways_reg       <= sacl_pkg::WAYS_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sacl_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data[sacl_pkg::SETB_W-1:0];
                sacl_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data[sacl_pkg::BLKB_W-1:0];
                sacl_pkg::CFG_WAYS:       ways_reg       <= cfg_data[sacl_pkg::WAYS_W-1:0];
                default:
                begin
                    ways_reg <= ways_reg;
                end
            endcase
        end
    end

    // address split
    logic [sacl_pkg::ADDR_W-1:0] above;
    logic [sacl_pkg::SET_W-1:0]  set_mask;
    logic [sacl_pkg::SET_W-1:0]  set_idx;
    logic [sacl_pkg::TAG_W-1:0]  tag_in;

    always_comb
    begin
        above = access_address >> block_bits_reg;
        for (int i = 0; i < sacl_pkg::SET_W; i++)
        begin
            set_mask[i] = (i < int'(set_bits_reg));
        end
        set_idx = above[sacl_pkg::SET_W-1:0] & set_mask;
        tag_in  = sacl_pkg::TAG_W'(above >> set_bits_reg);
    end

    // item registers and set store
    sacl_pkg::mode_t               mode_reg;
    logic [sacl_pkg::SET_W-1:0]    set_idx_reg;
    logic [sacl_pkg::TAG_W-1:0]    tag_reg;
    logic [sacl_pkg::MAX_SETS-1:0] row_valid_reg;
    logic                          row_ok_reg;
    sacl_pkg::row_t                rd_row_reg;
    sacl_pkg::row_t                mem [sacl_pkg::MAX_SETS];
    sacl_pkg::row_t                new_row;
    logic                          do_write;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg    <= sacl_pkg::mode_t'(mode);
            set_idx_reg <= set_idx;
            tag_reg     <= tag_in;
            rd_row_reg  <= mem[set_idx];
        end
        if (do_write)
        begin
            mem[set_idx_reg] <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                row_ok_reg <= row_valid_reg[set_idx];
            end
            if (do_write)
            begin
                row_valid_reg[set_idx_reg] <= 1'b1;
            end
        end
    end

    // lookup
    logic [NW-1:0]         act;
    logic [NW-1:0]         cur_valid;
    logic [NW-1:0][RW-1:0] cur_rank;
    logic [NW-1:0]         hit_vec;
    logic [NW-1:0]         free_vec;
    logic                  hit_any;
    logic                  free_any;
    logic [WW-1:0]         hit_way;
    logic [WW-1:0]         free_way;
    logic [WW-1:0]         vic_way;
    logic [RW-1:0]         vic_rank;
    logic [WW-1:0]         sel_way;
    logic [RW:0]           rank_lim;
    logic                  active;
    sacl_pkg::outcome_t    outcome_next;

    always_comb
    begin
        cur_valid = row_ok_reg ? rd_row_reg.valid : '0;
        cur_rank  = row_ok_reg ? rd_row_reg.rank : '0;
        for (int i = 0; i < NW; i++)
        begin
            act[i]      = (i == 0) || (i < int'(ways_reg));
            hit_vec[i]  = act[i] && cur_valid[i] && (rd_row_reg.tag[i] == tag_reg);
            free_vec[i] = act[i] && !cur_valid[i];
        end

        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (hit_vec[i] && !hit_any)
            begin
                hit_any = 1'b1;
                hit_way = WW'(i);
            end
            if (free_vec[i] && !free_any)
            begin
                free_any = 1'b1;
                free_way = WW'(i);
            end
        end

        vic_way  = '0;
        vic_rank = cur_rank[0];
        for (int i = 1; i < NW; i++)
        begin
            if (act[i] && (cur_rank[i] > vic_rank))
            begin
                vic_rank = cur_rank[i];
                vic_way  = WW'(i);
            end
        end

        priority if (hit_any)
        begin
            sel_way      = hit_way;
            rank_lim     = {1'b0, cur_rank[hit_way]};
            outcome_next = sacl_pkg::OUT_HIT;
        end
        else if (free_any)
        begin
            sel_way      = free_way;
            rank_lim     = (RW+1)'(NW);
            outcome_next = sacl_pkg::OUT_MISS;
        end
        else
        begin
            sel_way      = vic_way;
            rank_lim     = (RW+1)'(NW);
            outcome_next = sacl_pkg::OUT_EVICT;
        end

        active   = (mode_reg != sacl_pkg::MODE_FETCH);
        do_write = cmd.update && active;

        new_row.tag = rd_row_reg.tag;
        for (int i = 0; i < NW; i++)
        begin
            new_row.valid[i] = cur_valid[i] || (WW'(i) == sel_way);
            new_row.rank[i]  = cur_rank[i];
            if (WW'(i) == sel_way)
            begin
                new_row.rank[i] = '0;
                if (!hit_any)
                begin
                    new_row.tag[i] = tag_reg;
                end
            end
            else if (act[i] && cur_valid[i] && ({1'b0, cur_rank[i]} < rank_lim)
                     && (cur_rank[i] != RW'(NW - 1)))
            begin
                new_row.rank[i] = cur_rank[i] + 1'b1;
            end
        end
    end

    // results and totals
    sacl_pkg::outcome_t          outcome_reg;
    logic                        second_reg;
    logic                        second_next;
    logic [sacl_pkg::CNT_W-1:0]  hit_total_reg;
    logic [sacl_pkg::CNT_W-1:0]  miss_total_reg;
    logic [sacl_pkg::CNT_W-1:0]  evict_total_reg;

    assign second_next = (mode_reg == sacl_pkg::MODE_MODIFY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end
        else if (cmd.update)
        begin
            hit_total_reg   <= sat_inc(sat_inc(hit_total_reg, active && hit_any),
                                       second_next);
            miss_total_reg  <= sat_inc(miss_total_reg, active && !hit_any);
            evict_total_reg <= sat_inc(evict_total_reg,
                                       active && !hit_any && !free_any);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            outcome_reg <= active ? outcome_next : sacl_pkg::OUT_IGNORED;
            second_reg  <= second_next;
        end
    end

    assign outcome           = outcome_reg;
    assign modify_second_hit = second_reg;
    assign hit_total         = hit_total_reg;
    assign miss_total        = miss_total_reg;
    assign eviction_total    = evict_total_reg;

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> row_valid_reg[$past(set_idx_reg)])
        else $error("written set not marked valid");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (hit_total_reg >= $past(hit_total_reg)))
        else $error("hit total went down");

    a_outcome_active: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (outcome_reg != sacl_pkg::OUT_IGNORED))
        else $error("lookup reported as ignored");

    a_second_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && (mode_reg != sacl_pkg::MODE_MODIFY)) |=> !second_reg)
        else $error("second hit flagged outside a modify");

endmodule

`default_nettype wire

### hdl/set_assoc_cache_lru_sim.sv
// set-associative tag store with lru replacement, one memory access per item
//
// input: an item (mode, access_address) is taken at a rising edge with start
// high and busy low. busy is high for the one cycle of lookup that follows,
// so no new item is taken until it ends: the set's row is read synchronously
// as the item is taken, then compare, rank update and write-back follow.
//
// output: done pulses for one cycle, registered at the end of the lookup, with
// outcome, modify_second_hit and the three saturating totals. the receiver
// cannot stall; results are held in output registers, so the next item may
// be started in the same cycle that done is high.
//
// configuration: cfg_valid/cfg_ready with cfg_index (0 set bits, 1 block
// bits, 2 ways in use) and cfg_data. cfg_ready is always high; write only
// while idle.
//
// reset: all lines invalid with rank zero, totals zero, set bits, block bits
// and ways in use all 1. per-set valid flags clear at once, no clearing pass.
`default_nettype none

module set_assoc_cache_lru_sim (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sacl_pkg::MODE_W-1:0]        mode,
    input  wire logic [sacl_pkg::ADDR_W-1:0]        access_address,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    done,
    output logic [sacl_pkg::OUTCOME_W-1:0]          outcome,
    output logic                                    modify_second_hit,
    output logic [sacl_pkg::CNT_W-1:0]              hit_total,
    output logic [sacl_pkg::CNT_W-1:0]              miss_total,
    output logic [sacl_pkg::CNT_W-1:0]              eviction_total
);

    sacl_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sacl_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .mode              (mode),
        .access_address    (access_address),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .outcome           (outcome),
        .modify_second_hit (modify_second_hit),
        .hit_total         (hit_total),
        .miss_total        (miss_total),
        .eviction_total    (eviction_total)
    );

endmodule

`default_nettype wire
